>>> rtl/core/lfpd_pkg.sv
package lfpd_pkg;

  localparam int SENSOR_COUNT = 8;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TARGET    = 3'd0;
  localparam logic [2:0] REG_GAIN_P    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE      = 3'd3;
  localparam logic [2:0] REG_LOST_ERR  = 3'd4;
  localparam logic [2:0] REG_LOST_THR  = 3'd5;

  // Indicator codes.
  localparam logic [1:0] IND_CENTRED  = 2'd0;
  localparam logic [1:0] IND_LOST_POS = 2'd1;
  localparam logic [1:0] IND_LOST_NEG = 2'd2;

  // Request to the serial divider: magnitude of the weighted sum over the count.
  typedef struct packed {
    logic       start;
    logic [6:0] dividend;
    logic [3:0] divisor;
  } div_req_t;

  // Request to the serial multiply-accumulate unit.
  typedef struct packed {
    logic              start;
    logic signed [7:0] err;
    logic signed [8:0] diff;
    logic [5:0]        gain_p;
    logic [5:0]        gain_d;
  } mac_req_t;

  function automatic logic signed [6:0] sensor_weight(input logic [2:0] idx);
    logic signed [6:0] w;
    case (idx)
      3'd0:    w = -7'sd30;
      3'd1:    w = -7'sd25;
      3'd2:    w = -7'sd15;
      3'd3:    w = -7'sd5;
      3'd4:    w = 7'sd5;
      3'd5:    w = 7'sd15;
      3'd6:    w = 7'sd25;
      default: w = 7'sd30;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/lfpd_divider.sv
module lfpd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  lfpd_pkg::div_req_t req,
  output logic              done,
  output logic [6:0]        quotient
);
  import lfpd_pkg::*;

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [6:0] dq_r, dq_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic [3:0] div_r, div_nxt;
  logic [3:0] trial;
  logic [3:0] trial_sub;
  logic       qbit;

  // Restoring division, one quotient bit a cycle, dividend bits shifting out at the top.
  assign trial     = {rem_r, dq_r[6]};
  assign qbit      = (trial >= div_r);
  assign trial_sub = trial - div_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd6;
      dq_nxt   = req.dividend;
      rem_nxt  = 3'd0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[5:0], qbit};
      rem_nxt = qbit ? trial_sub[2:0] : trial[2:0];
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> rtl/core/lfpd_mac.sv
module lfpd_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  lfpd_pkg::mac_req_t  req,
  output logic                done,
  output logic signed [15:0]  acc
);
  import lfpd_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic signed [15:0] a_r, a_nxt;
  logic signed [15:0] b_r, b_nxt;
  logic [5:0]         gp_r, gp_nxt;
  logic [5:0]         gd_r, gd_nxt;
  logic signed [15:0] acc_r, acc_nxt;
  logic signed [15:0] term_a, term_b;

  // One bit of each gain a cycle, least significant first; operands double each step.
  assign term_a = gp_r[0] ? a_r : 16'sd0;
  assign term_b = gd_r[0] ? b_r : 16'sd0;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    gp_nxt   = gp_r;
    gd_nxt   = gd_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd5;
      a_nxt    = 16'(req.err);
      b_nxt    = 16'(req.diff);
      gp_nxt   = req.gain_p;
      gd_nxt   = req.gain_d;
      acc_nxt  = 16'sd0;
    end else if (busy_r) begin
      acc_nxt = acc_r + term_a + term_b;
      a_nxt   = a_r <<< 1;
      b_nxt   = b_r <<< 1;
      gp_nxt  = gp_r >> 1;
      gd_nxt  = gd_r >> 1;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    gp_r  <= gp_nxt;
    gd_r  <= gd_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

>>> rtl/core/line_follower_pd_steering.sv
// Channel  Direction  Handshake                Payload
// in_      slave      in_tvalid / in_tready    tdata[7:0] sensor_bits
// out_     master     out_tvalid / out_tready  tdata left, right, error; tuser indicator
// cfg_     slave      cfg_valid / cfg_ready    cfg_index register, cfg_data value
//
// An item passes through the serial divider, which produces one quotient bit a cycle,
// and the serial multiply-accumulate unit, which consumes one bit of each gain a cycle,
// with sequencing states between and around them.
// When no sensor sees the line the divider is skipped.
// Reset is synchronous and active low; it restores the register defaults and clears the
// remembered error. A stalled result sits in the output register; the next item is taken
// meanwhile and waits at its final step until that register is free.
module line_follower_pd_steering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sensor_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] left_drive, [15:8] right_drive, [23:16] error_value
  output logic [1:0]  out_tuser,  // [1:0] indicator
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lfpd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Configuration registers.
  logic signed [5:0] target_r;
  logic [5:0]        gain_p_r;
  logic [5:0]        gain_d_r;
  logic [7:0]        base_r;
  logic [5:0]        lost_err_r;
  logic [5:0]        lost_thr_r;

  logic [2:0]        state_r, state_nxt;
  logic signed [7:0] prev_r;
  logic signed [7:0] err_r, err_nxt;
  logic              neg_r;
  logic              lost_r;
  logic signed [7:0] lost_val_r;

  logic              out_valid_r;
  logic [23:0]       out_data_r;
  logic [1:0]        out_user_r;

  // Weighted sum and count of the active sensors, formed as the item is accepted.
  logic signed [7:0] wsum;
  logic [3:0]        wcount;
  logic [6:0]        wmag;
  logic              accept;

  always_comb begin
    wsum   = 8'sd0;
    wcount = 4'd0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (in_tdata[i]) begin
        wsum   = wsum + 8'(sensor_weight(3'(i)));
        wcount = wcount + 4'd1;
      end
    end
  end

  assign wmag   = wsum[7] ? 7'(-wsum) : wsum[6:0];
  assign accept = in_tvalid && in_tready;

  // With the line lost the remembered error picks the side; the negative test comes first.
  logic signed [8:0] prev_ext, thr_ext;
  logic signed [7:0] lost_pick;
  assign prev_ext = 9'(prev_r);
  assign thr_ext  = $signed({3'b000, lost_thr_r});

  always_comb begin
    if (prev_ext <= -thr_ext) begin
      lost_pick = -$signed({2'b00, lost_err_r});
    end else if (prev_ext >= thr_ext) begin
      lost_pick = $signed({2'b00, lost_err_r});
    end else begin
      lost_pick = 8'sd0;
    end
  end

  div_req_t   div_req;
  logic       div_done;
  logic [6:0] div_q;

  assign div_req.start    = accept && (wcount != 4'd0);
  assign div_req.dividend = wmag;
  assign div_req.divisor  = wcount;

  lfpd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Error: signed quotient plus the set point, saturated to eight bits; with the line lost, the picked lost value.
  logic signed [9:0] err_wide;
  assign err_wide = 10'(target_r) + (neg_r ? -$signed({3'b000, div_q}) : $signed({3'b000, div_q}));

  always_comb begin
    if (lost_r) begin
      err_nxt = lost_val_r;
    end else if (err_wide > 10'sd127) begin
      err_nxt = 8'sd127;
    end else if (err_wide < -10'sd128) begin
      err_nxt = -8'sd128;
    end else begin
      err_nxt = err_wide[7:0];
    end
  end

  mac_req_t           mac_req;
  logic               mac_done;
  logic signed [15:0] corr;

  assign mac_req.start  = (state_r == S_ERR);
  assign mac_req.err    = err_nxt;
  assign mac_req.diff   = 9'(err_nxt) - 9'(prev_r);
  assign mac_req.gain_p = gain_p_r;
  assign mac_req.gain_d = gain_d_r;

  lfpd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .done  (mac_done),
    .acc   (corr)
  );

  // Drives: the correction slows one motor, clamped at zero.
  logic signed [16:0] base_ext, right_sum, left_sum;
  logic [7:0]         left_drv, right_drv;
  logic [1:0]         ind;
  logic signed [8:0]  lost_ext;

  assign base_ext  = $signed({9'b0, base_r});
  assign right_sum = base_ext + 17'(corr);
  assign left_sum  = base_ext - 17'(corr);
  assign lost_ext  = $signed({3'b000, lost_err_r});

  always_comb begin
    left_drv  = base_r;
    right_drv = base_r;
    if (corr < 0) begin
      right_drv = right_sum[16] ? 8'd0 : right_sum[7:0];
    end else if (corr > 0) begin
      left_drv = left_sum[16] ? 8'd0 : left_sum[7:0];
    end
    if (9'(err_r) == lost_ext) begin
      ind = IND_LOST_POS;
    end else if (9'(err_r) == -lost_ext) begin
      ind = IND_LOST_NEG;
    end else begin
      ind = IND_CENTRED;
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (wcount != 4'd0) ? S_DIV : S_ERR;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR:  state_nxt = S_MAC;
      S_MAC: begin
        if (mac_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= 8'sd0;
      out_valid_r <= 1'b0;
      target_r    <= 6'sd0;
      gain_p_r    <= 6'd5;
      gain_d_r    <= 6'd15;
      base_r      <= 8'd255;
      lost_err_r  <= 6'd40;
      lost_thr_r  <= 6'd5;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_TARGET:   target_r   <= $signed(cfg_data[5:0]);
          REG_GAIN_P:   gain_p_r   <= cfg_data[5:0];
          REG_GAIN_D:   gain_d_r   <= cfg_data[5:0];
          REG_BASE:     base_r     <= cfg_data;
          REG_LOST_ERR: lost_err_r <= cfg_data[5:0];
          REG_LOST_THR: lost_thr_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        if (err_r != 8'sd0) begin
          prev_r <= err_r;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      neg_r      <= wsum[7];
      lost_r     <= (wcount == 4'd0);
      lost_val_r <= lost_pick;
    end
    if (state_r == S_ERR) begin
      err_r <= err_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {err_r, right_drv, left_drv};
      out_user_r <= ind;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_ready  = 1'b1;

endmodule

>>> rtl/core/lfpd_checker.sv
module lfpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [7:0]  cfg_data
);
  import lfpd_pkg::*;

  // A result held back by the sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Only one item is in work: the input closes after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open while an item is in work");

  // The indicator never carries the unused code.
  a_ind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == IND_CENTRED || out_tuser == IND_LOST_POS ||
                    out_tuser == IND_LOST_NEG))
    else $error("indicator code out of range");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind line_follower_pd_steering lfpd_checker u_lfpd_checker (.*);
